// ===== hw/rtl/tcd_pkg.sv =====
// Shared types and constants for the TCP connection demultiplexer.
// No dependencies; every other file of the block but tcd_ifs imports this package.
package tcd_pkg;

	localparam int DEF_ENTRIES = 16;

	// Entry status codes. Any status other than free or listening counts as connected.
	localparam logic [1:0] STATUS_FREE      = 2'd0;
	localparam logic [1:0] STATUS_LISTEN    = 2'd1;
	localparam logic [1:0] STATUS_CONNECTED = 2'd2;

	localparam logic [3:0] MCAST_NIBBLE = 4'hE;
	localparam int         TCP_MIN_HDR  = 20;

	typedef enum logic [2:0] {
		V_BCAST   = 3'd0,
		V_BADHDR  = 3'd1,
		V_RESET   = 3'd2,
		V_CONN    = 3'd3,
		V_LISTEN  = 3'd4,
		V_WRITTEN = 3'd5
	} verdict_t;

	typedef struct packed {
		verdict_t   verdict;
		logic [3:0] match_index;
	} result_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] local_addr;
		logic [31:0] remote_addr;
		logic [15:0] local_port;
		logic [15:0] remote_port;
	} entry_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_DONE
	} seq_state_t;

endpackage

// ===== hw/rtl/tcd_ifs.sv =====
// Request and result channel interfaces of the TCP connection demultiplexer.
// Plain valid/ready handshake; no dependencies.
interface tcd_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [3:0]  entry_index;
	logic [1:0]  entry_status;
	logic [31:0] src_ip;
	logic [31:0] dst_ip;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic        link_broadcast;
	logic [15:0] total_len;
	logic [5:0]  ip_hdr_bytes;
	logic [5:0]  tcp_hdr_bytes;
	logic        checksum_ok;

	modport source (
		output valid, op, entry_index, entry_status, src_ip, dst_ip, src_port, dst_port,
		output link_broadcast, total_len, ip_hdr_bytes, tcp_hdr_bytes, checksum_ok,
		input  ready
	);
	modport sink (
		input  valid, op, entry_index, entry_status, src_ip, dst_ip, src_port, dst_port,
		input  link_broadcast, total_len, ip_hdr_bytes, tcp_hdr_bytes, checksum_ok,
		output ready
	);
endinterface

interface tcd_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] verdict;
	logic [3:0] match_index;

	modport source (output valid, verdict, match_index, input ready);
	modport sink (input valid, verdict, match_index, output ready);
endinterface

// ===== hw/rtl/tcp_connection_demux_unit.sv =====
// Top level of the TCP connection demultiplexer: sequencer, table memory and result register.
// Depends on tcd_pkg, tcd_ifs, tcd_mem and tcd_seq.
//
// Each request either writes one table entry (verdict written) or classifies a segment.
// A write, a broadcast or multicast drop and a bad header drop wait in the sequencer's result
// register and move into the output register once it is free. A classify request that passes
// the checks scans the table through the single read port of the entry memory, one entry per
// cycle; the memory's registered read data feeds the compare stage, and the final verdict
// passes through the result register into the output register. The next request can be
// taken once the result has moved into the output register. Requests are handled one at a
// time, but a new request is taken while the previous result still waits in the output
// register. Among connected entries the lowest index with a full four-tuple match wins;
// otherwise a listener on the destination port is chosen, a specific local address beating
// the wildcard 0. After reset all entries read as free; no clearing pass is needed.
module tcp_connection_demux_unit import tcd_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic       clk,
	input  logic       arst_n,
	tcd_req_if.sink    req,
	tcd_rsp_if.source  rsp
);

	localparam int IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

	mem_ctl_t         mem_ctl;
	logic [IDX_W-1:0] wr_addr, rd_addr;
	entry_t           wr_data, rd_data;
	result_t          res, out_q;
	logic             res_vld, slot_free, out_vld_q, load;

	tcd_seq #(.ENTRIES(ENTRIES)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.mem_ctl  (mem_ctl),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.res      (res),
		.res_vld  (res_vld),
		.slot_free(slot_free)
	);

	tcd_mem #(.ENTRIES(ENTRIES)) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.mem_ctl(mem_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign slot_free = !out_vld_q || rsp.ready;
	assign load      = res_vld && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (slot_free) begin
			out_vld_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.verdict     = out_q.verdict;
	assign rsp.match_index = out_q.match_index;

	a_no_wr_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_ctl.wr_en && mem_ctl.rd_en))
		else $error("table write overlaps a lookup read");

	a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while the previous one is still in flight");

	a_index_only_on_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (out_q.verdict != V_CONN) && (out_q.verdict != V_LISTEN)
		|-> out_q.match_index == '0)
		else $error("match index set on a verdict without a selected entry");

	a_result_follows_done: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_vld_q && !res_vld)
		else $error("result hand-off did not release the sequencer");

endmodule

// ===== hw/rtl/tcd_mem.sv =====
// Connection table storage: one synchronous memory of entries with registered read data.
// Per-entry valid bits make unwritten entries read as free. Depends on tcd_pkg.
module tcd_mem import tcd_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mem_ctl_t                               mem_ctl,
	input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
	input  entry_t                                 wr_data,
	input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
	output entry_t                                 rd_data
);

	entry_t               mem_q [ENTRIES];
	logic [ENTRIES-1:0]   vld_q;
	entry_t               rd_raw_s1;
	logic                 rd_vld_s1;

	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (mem_ctl.rd_en) begin
			rd_raw_s1 <= mem_q[rd_addr];
			rd_vld_s1 <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (mem_ctl.wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_comb begin
		rd_data = rd_raw_s1;
		if (!rd_vld_s1) begin
			rd_data.status = STATUS_FREE;
		end
	end

endmodule

// ===== hw/rtl/tcd_seq.sv =====
// Request sequencer: header checks, table writes and the entry-by-entry lookup scan.
// Drives the table memory in tcd_mem. Depends on tcd_pkg and tcd_ifs.
module tcd_seq import tcd_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	tcd_req_if.sink                                req,
	output mem_ctl_t                               mem_ctl,
	output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
	output entry_t                                 wr_data,
	output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
	input  entry_t                                 rd_data,
	output result_t                                res,
	output logic                                   res_vld,
	input  logic                                   slot_free
);

	localparam int IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	seq_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             conn_found_q, lis_found_q;
	logic [IDX_W-1:0] conn_idx_q, lis_idx_q;
	logic             conn_found_d, lis_found_d;
	logic [IDX_W-1:0] conn_idx_d, lis_idx_d;
	logic [31:0]      sip_q, dip_q;
	logic [15:0]      sport_q, dport_q;
	result_t          res_q, res_d;
	logic             res_load;

	logic accept, drop_mcast, drop_hdr, wr_in_range;
	logic is_listen, is_conn, lis_hit, conn_hit, last_cmp;

	assign req.ready = (state_q == SEQ_IDLE);
	assign accept    = req.valid && (state_q == SEQ_IDLE);

	assign drop_mcast = req.link_broadcast || (req.dst_ip[31:28] == MCAST_NIBBLE);
	assign drop_hdr   = ({1'b0, req.total_len} < 17'(req.ip_hdr_bytes) + 17'(TCP_MIN_HDR))
		|| (req.total_len < 16'(req.ip_hdr_bytes) + 16'(req.tcp_hdr_bytes))
		|| !req.checksum_ok;
	assign wr_in_range = 32'(req.entry_index) < 32'(ENTRIES);

	// Writes go straight to the table on acceptance; a scan never runs at the same time.
	assign mem_ctl.wr_en = accept && req.op && wr_in_range;
	assign wr_addr       = IDX_W'(req.entry_index);
	assign wr_data       = '{status: req.entry_status, local_addr: req.dst_ip,
		remote_addr: req.src_ip, local_port: req.dst_port, remote_port: req.src_port};

	assign mem_ctl.rd_en = (state_q == SEQ_SCAN) && (cnt_q != CNT_W'(ENTRIES));
	assign rd_addr       = cnt_q[IDX_W-1:0];

	// Compare stage: the entry read in the previous cycle against the held segment.
	assign is_listen = (rd_data.status == STATUS_LISTEN);
	assign is_conn   = (rd_data.status != STATUS_FREE) && (rd_data.status != STATUS_LISTEN);
	assign lis_hit   = cmp_vld_s1 && is_listen && (rd_data.local_port == dport_q)
		&& ((rd_data.local_addr == dip_q) || ((rd_data.local_addr == '0) && !lis_found_q));
	assign conn_hit  = cmp_vld_s1 && is_conn && !conn_found_q
		&& (rd_data.remote_addr == sip_q) && (rd_data.local_addr == dip_q)
		&& (rd_data.remote_port == sport_q) && (rd_data.local_port == dport_q);
	assign last_cmp  = cmp_vld_s1 && (cmp_idx_s1 == IDX_W'(ENTRIES - 1));

	assign conn_found_d = conn_found_q || conn_hit;
	assign conn_idx_d   = conn_hit ? cmp_idx_s1 : conn_idx_q;
	assign lis_found_d  = lis_found_q || lis_hit;
	assign lis_idx_d    = lis_hit ? cmp_idx_s1 : lis_idx_q;

	always_comb begin
		state_d  = state_q;
		res_load = 1'b0;
		res_d    = '{verdict: V_RESET, match_index: '0};
		case (state_q)
			SEQ_IDLE: begin
				if (accept) begin
					if (req.op) begin
						res_d    = '{verdict: V_WRITTEN, match_index: '0};
						res_load = 1'b1;
						state_d  = SEQ_DONE;
					end else if (drop_mcast) begin
						res_d    = '{verdict: V_BCAST, match_index: '0};
						res_load = 1'b1;
						state_d  = SEQ_DONE;
					end else if (drop_hdr) begin
						res_d    = '{verdict: V_BADHDR, match_index: '0};
						res_load = 1'b1;
						state_d  = SEQ_DONE;
					end else begin
						state_d = SEQ_SCAN;
					end
				end
			end
			SEQ_SCAN: begin
				if (last_cmp) begin
					res_load = 1'b1;
					state_d  = SEQ_DONE;
					if (conn_found_d) begin
						res_d = '{verdict: V_CONN, match_index: 4'(conn_idx_d)};
					end else if (lis_found_d) begin
						res_d = '{verdict: V_LISTEN, match_index: 4'(lis_idx_d)};
					end
				end
			end
			SEQ_DONE: begin
				if (slot_free) begin
					state_d = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= SEQ_IDLE;
			cnt_q        <= '0;
			cmp_vld_s1   <= 1'b0;
			conn_found_q <= 1'b0;
			lis_found_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q        <= '0;
				cmp_vld_s1   <= 1'b0;
				conn_found_q <= 1'b0;
				lis_found_q  <= 1'b0;
			end else begin
				if (mem_ctl.rd_en) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				cmp_vld_s1   <= mem_ctl.rd_en;
				conn_found_q <= conn_found_d;
				lis_found_q  <= lis_found_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sip_q   <= req.src_ip;
			dip_q   <= req.dst_ip;
			sport_q <= req.src_port;
			dport_q <= req.dst_port;
		end
		cmp_idx_s1 <= rd_addr;
		conn_idx_q <= conn_idx_d;
		lis_idx_q  <= lis_idx_d;
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res     = res_q;
	assign res_vld = (state_q == SEQ_DONE);

endmodule

// ===== dv/tcp_connection_demux_unit_tb.sv =====
// Self-checking testbench for the TCP connection demultiplexer: directed table, then
// random table writes and segment lookups, checked against a behavioral lookup table.
// Depends on tcd_pkg, tcd_ifs and the tcp_connection_demux_unit RTL.
`timescale 1ns / 100ps

module tcp_connection_demux_unit_tb;
	import tcd_pkg::*;

	localparam int ENTRIES      = DEF_ENTRIES;
	localparam int CLK_PERIOD   = 10;
	localparam int RANDOM_ITEMS = 650;
	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 25;
	localparam int MAX_REPORTS  = 10;

	localparam logic       OP_LOOKUP = 1'b0;
	localparam logic       OP_WRITE  = 1'b1;
	// Status three is not defined by the package, but the block treats it as connected.
	localparam logic [1:0] STATUS_ALT_CONNECTED = 2'd3;

	localparam logic [31:0] HOST_A = 32'h0A00_0001;
	localparam logic [31:0] HOST_B = 32'hC0A8_0105;
	localparam logic [31:0] ALL_ONES_ADDR = 32'hFFFF_FFFF;
	localparam logic [31:0] ADDR_POOL [4] = '{HOST_A, 32'h0A00_0002, HOST_B, 32'hFFFF_FFFE};
	localparam logic [15:0] PORT_POOL [4] = '{16'd80, 16'd443, 16'd22, 16'd1234};

	typedef struct packed {
		logic        op;
		logic [3:0]  entry_index;
		logic [1:0]  entry_status;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic        link_broadcast;
		logic [15:0] total_len;
		logic [5:0]  ip_hdr_bytes;
		logic [5:0]  tcp_hdr_bytes;
		logic        checksum_ok;
	} segment_req_t;

	typedef struct {
		segment_req_t req;
		bit           typed;
		result_t      want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;

	tcd_req_if req_ch ();
	tcd_rsp_if rsp_ch ();

	tcp_connection_demux_unit #(.ENTRIES(ENTRIES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	entry_t  slot_mirror [ENTRIES];
	result_t pending_verdicts [$];
	int      mismatches  = 0;
	int      hold_asked  = 0;

	// Table update and classification, one request at a time.
	function automatic result_t classify_segment(input segment_req_t r);
		result_t    res;
		bit         conn_hit, lis_hit;
		logic [3:0] conn_at, lis_at;
		entry_t     e;
		res.verdict = V_RESET;
		res.match_index = '0;
		conn_hit = 1'b0;
		lis_hit = 1'b0;
		conn_at = '0;
		lis_at = '0;
		if (r.op == OP_WRITE) begin
			if (int'(r.entry_index) < ENTRIES)
				slot_mirror[r.entry_index] = '{r.entry_status, r.dst_ip, r.src_ip,
					r.dst_port, r.src_port};
			res.verdict = V_WRITTEN;
		end else if (r.link_broadcast || r.dst_ip[31:28] == MCAST_NIBBLE) begin
			res.verdict = V_BCAST;
		end else if (int'(r.total_len) < int'(r.ip_hdr_bytes) + TCP_MIN_HDR ||
				int'(r.total_len) < int'(r.ip_hdr_bytes) + int'(r.tcp_hdr_bytes) ||
				!r.checksum_ok) begin
			res.verdict = V_BADHDR;
		end else begin
			for (int k = 0; k < ENTRIES; k++) begin
				e = slot_mirror[k];
				if (e.status == STATUS_LISTEN) begin
					// A specific address always wins; a wildcard only fills an empty slot.
					if (e.local_port == r.dst_port &&
							(e.local_addr == r.dst_ip || (e.local_addr == '0 && !lis_hit))) begin
						lis_hit = 1'b1;
						lis_at = 4'(k);
					end
				end else if (e.status != STATUS_FREE && !conn_hit &&
						e.remote_addr == r.src_ip && e.local_addr == r.dst_ip &&
						e.remote_port == r.src_port && e.local_port == r.dst_port) begin
					conn_hit = 1'b1;
					conn_at = 4'(k);
				end
			end
			if (conn_hit) begin
				res.verdict = V_CONN;
				res.match_index = conn_at;
			end else if (lis_hit) begin
				res.verdict = V_LISTEN;
				res.match_index = lis_at;
			end
		end
		return res;
	endfunction

	function automatic segment_req_t mk(input logic op, input logic [3:0] idx,
			input logic [1:0] st, input logic [31:0] sip, input logic [31:0] dip,
			input logic [15:0] sport, input logic [15:0] dport, input logic bcast,
			input logic [15:0] tlen, input logic [5:0] iph, input logic [5:0] tcph,
			input logic csok);
		return '{op, idx, st, sip, dip, sport, dport, bcast, tlen, iph, tcph, csok};
	endfunction

	function automatic void make_header_valid(inout segment_req_t r);
		r.link_broadcast = 1'b0;
		r.ip_hdr_bytes = 6'($urandom_range(20, 60));
		r.tcp_hdr_bytes = 6'($urandom_range(20, 60));
		r.total_len = 16'($urandom_range(int'(r.ip_hdr_bytes) + int'(r.tcp_hdr_bytes), 65535));
		r.checksum_ok = ($urandom_range(0, 19) != 0);
	endfunction

	// Mostly writes and lookups that hit the current table, the rest noise and bad segments.
	function automatic segment_req_t random_request();
		segment_req_t r;
		entry_t       e;
		int           pick;
		r = '{1'($urandom), 4'($urandom), 2'($urandom), $urandom, $urandom, 16'($urandom),
			16'($urandom), 1'($urandom), 16'($urandom), 6'($urandom), 6'($urandom),
			1'($urandom)};
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			r.op = OP_WRITE;
			pick = $urandom_range(0, 99);
			r.entry_status = (pick < 40) ? STATUS_LISTEN : (pick < 85) ? STATUS_CONNECTED :
				(pick < 95) ? STATUS_FREE : STATUS_ALT_CONNECTED;
			r.dst_ip = (r.entry_status == STATUS_LISTEN && $urandom_range(0, 2) == 0) ?
				'0 : ADDR_POOL[$urandom_range(0, 3)];
			r.src_ip = ADDR_POOL[$urandom_range(0, 3)];
			r.dst_port = PORT_POOL[$urandom_range(0, 3)];
			r.src_port = PORT_POOL[$urandom_range(0, 3)];
		end else if (pick < 75) begin
			r.op = OP_LOOKUP;
			e = slot_mirror[$urandom_range(0, ENTRIES - 1)];
			r.src_ip = ADDR_POOL[$urandom_range(0, 3)];
			r.dst_ip = ADDR_POOL[$urandom_range(0, 3)];
			r.src_port = PORT_POOL[$urandom_range(0, 3)];
			r.dst_port = PORT_POOL[$urandom_range(0, 3)];
			if (e.status == STATUS_LISTEN) begin
				r.dst_port = e.local_port;
				if (e.local_addr != '0)
					r.dst_ip = e.local_addr;
			end else if (e.status != STATUS_FREE) begin
				r.src_ip = e.remote_addr;
				r.dst_ip = e.local_addr;
				r.src_port = e.remote_port;
				r.dst_port = e.local_port;
			end
			if ($urandom_range(0, 4) == 0)
				r.src_port = PORT_POOL[$urandom_range(0, 3)];
			make_header_valid(r);
		end else begin
			r.op = OP_LOOKUP;
			case ($urandom_range(0, 3))
				0: r.link_broadcast = 1'b1;
				1: r.dst_ip[31:28] = MCAST_NIBBLE;
				2: r.checksum_ok = 1'b1;
				default: make_header_valid(r);
			endcase
		end
		return r;
	endfunction

	function automatic int pick_gap(input int n);
		int pick;
		pick = $urandom_range(0, 9);
		if ((n / 60) % 4 == 3 || pick < 6)
			return 0;
		if (pick < 9)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic put_request(input segment_req_t r);
		req_ch.op <= r.op;
		req_ch.entry_index <= r.entry_index;
		req_ch.entry_status <= r.entry_status;
		req_ch.src_ip <= r.src_ip;
		req_ch.dst_ip <= r.dst_ip;
		req_ch.src_port <= r.src_port;
		req_ch.dst_port <= r.dst_port;
		req_ch.link_broadcast <= r.link_broadcast;
		req_ch.total_len <= r.total_len;
		req_ch.ip_hdr_bytes <= r.ip_hdr_bytes;
		req_ch.tcp_hdr_bytes <= r.tcp_hdr_bytes;
		req_ch.checksum_ok <= r.checksum_ok;
	endtask

	// Called at a rising edge; returns at the edge where the request is taken.
	task automatic offer_request(input segment_req_t r, input bit typed, input result_t want);
		result_t predicted;
		put_request(r);
		req_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predicted = classify_segment(r);
		pending_verdicts.push_back(typed ? want : predicted);
	endtask

	task automatic idle_gap(input int gap);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(input string why, input result_t want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t mismatch (%s): expected verdict %0d index %0d, got verdict %0d index %0d",
				$realtime, why, want.verdict, want.match_index, rsp_ch.verdict,
				rsp_ch.match_index);
	endtask

	directed_row_t directed_tbl [25];

	initial begin
		int gap_free_left;
		gap_free_left = 0;
		for (int k = 0; k < ENTRIES; k++)
			slot_mirror[k] = '{STATUS_FREE, '0, '0, '0, '0};
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		put_request('0);

		directed_tbl = '{
			'{mk(OP_LOOKUP, 0, 0, HOST_B, HOST_A, 1234, 80, 0, 1500, 20, 20, 1), 1,
				'{V_RESET, 4'd0}},
			'{mk(OP_LOOKUP, 0, 0, HOST_B, HOST_A, 1234, 80, 1, 1500, 20, 20, 1), 1,
				'{V_BCAST, 4'd0}},
			'{mk(OP_LOOKUP, 0, 0, HOST_B, 32'hE000_0000, 1, 2, 0, 1500, 20, 20, 1), 1,
				'{V_BCAST, 4'd0}},
			'{mk(OP_LOOKUP, 0, 0, HOST_B, 32'hEFFF_FFFF, 1, 2, 0, 1500, 20, 20, 1), 1,
				'{V_BCAST, 4'd0}},
			'{mk(OP_LOOKUP, 15, 3, 0, ALL_ONES_ADDR, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 63, 63, 1),
				1, '{V_RESET, 4'd0}},
			'{mk(OP_LOOKUP, 0, 0, HOST_B, HOST_A, 1234, 80, 0, 39, 20, 20, 1), 1,
				'{V_BADHDR, 4'd0}},
			'{mk(OP_LOOKUP, 0, 0, HOST_B, HOST_A, 1234, 80, 0, 79, 20, 60, 1), 1,
				'{V_BADHDR, 4'd0}},
			'{mk(OP_LOOKUP, 0, 0, HOST_B, HOST_A, 1234, 80, 0, 1500, 20, 20, 0), 1,
				'{V_BADHDR, 4'd0}},
			'{mk(OP_LOOKUP, 0, 0, HOST_B, HOST_A, 1234, 80, 0, 0, 0, 0, 1), 1,
				'{V_BADHDR, 4'd0}},
			'{mk(OP_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 20, 0, 0, 1), 1, '{V_RESET, 4'd0}},
			'{mk(OP_WRITE, 0, STATUS_LISTEN, 0, 0, 0, 80, 0, 0, 0, 0, 0), 1,
				'{V_WRITTEN, 4'd0}},
			'{mk(OP_WRITE, 3, STATUS_LISTEN, 0, HOST_A, 0, 80, 0, 0, 0, 0, 0), 1,
				'{V_WRITTEN, 4'd0}},
			'{mk(OP_WRITE, 5, STATUS_CONNECTED, HOST_B, HOST_A, 1234, 80, 0, 0, 0, 0, 0), 1,
				'{V_WRITTEN, 4'd0}},
			'{mk(OP_WRITE, 7, STATUS_CONNECTED, HOST_B, HOST_A, 1234, 80, 0, 0, 0, 0, 0), 1,
				'{V_WRITTEN, 4'd0}},
			'{mk(OP_WRITE, 15, STATUS_ALT_CONNECTED, ALL_ONES_ADDR, ALL_ONES_ADDR, 16'hFFFF,
				16'hFFFF, 1, 16'hFFFF, 63, 63, 1), 1, '{V_WRITTEN, 4'd0}},
			'{mk(OP_WRITE, 9, STATUS_LISTEN, 0, HOST_A, 0, 443, 0, 0, 0, 0, 0), 1,
				'{V_WRITTEN, 4'd0}},
			'{mk(OP_WRITE, 12, STATUS_LISTEN, 0, 0, 0, 443, 0, 0, 0, 0, 0), 1,
				'{V_WRITTEN, 4'd0}},
			'{mk(OP_LOOKUP, 0, 0, HOST_B, HOST_A, 1234, 80, 0, 1500, 20, 20, 1), 0,
				'{V_RESET, 4'd0}},
			'{mk(OP_LOOKUP, 0, 0, HOST_B, 32'h0A00_0002, 999, 80, 0, 1500, 20, 20, 1), 0,
				'{V_RESET, 4'd0}},
			'{mk(OP_LOOKUP, 0, 0, HOST_B, HOST_A, 999, 80, 0, 1500, 20, 20, 1), 0,
				'{V_RESET, 4'd0}},
			'{mk(OP_LOOKUP, 0, 0, ALL_ONES_ADDR, ALL_ONES_ADDR, 16'hFFFF, 16'hFFFF, 0,
				16'hFFFF, 63, 63, 1), 0, '{V_RESET, 4'd0}},
			'{mk(OP_LOOKUP, 0, 0, HOST_B, HOST_A, 5000, 443, 0, 1500, 20, 20, 1), 0,
				'{V_RESET, 4'd0}},
			'{mk(OP_LOOKUP, 0, 0, HOST_B, 32'h0A00_0002, 5000, 443, 0, 1500, 20, 20, 1), 0,
				'{V_RESET, 4'd0}},
			'{mk(OP_WRITE, 5, STATUS_FREE, HOST_B, HOST_A, 1234, 80, 0, 0, 0, 0, 0), 1,
				'{V_WRITTEN, 4'd0}},
			'{mk(OP_LOOKUP, 0, 0, HOST_B, HOST_A, 1234, 80, 0, 1500, 20, 20, 1), 0,
				'{V_RESET, 4'd0}}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_tbl[i]) begin
			offer_request(directed_tbl[i].req, directed_tbl[i].typed, directed_tbl[i].want);
			idle_gap(pick_gap(i));
		end
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			offer_request(random_request(), 1'b0, '{V_RESET, 4'd0});
			if (n == 200) begin
				// Ask the result side for a long hold-off and keep requests coming meanwhile.
				hold_asked++;
				gap_free_left = 12;
			end
			if (n == 400)
				drain_results();
			else if (gap_free_left > 0)
				gap_free_left--;
			else
				idle_gap(pick_gap(n));
		end
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Result side: check each accepted result, then decide ready for the next cycle.
	initial begin
		int      cyc, hold_left, stall_left, hold_served;
		result_t want;
		cyc = 0;
		hold_left = 0;
		stall_left = 0;
		hold_served = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_verdicts.size() == 0) begin
					report_mismatch("unexpected result", '{V_RESET, 4'd0});
				end else begin
					want = pending_verdicts.pop_front();
					if (rsp_ch.verdict !== want.verdict || rsp_ch.match_index !== want.match_index)
						report_mismatch("wrong field", want);
				end
			end
			if (hold_served < hold_asked) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if ((cyc / 500) % 4 == 0) begin
				rsp_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
					$urandom_range(1, 3);
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Ends the run if neither channel moves for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule

// ===== files.f =====
hw/rtl/tcd_pkg.sv
hw/rtl/tcd_ifs.sv
hw/rtl/tcd_mem.sv
hw/rtl/tcd_seq.sv
hw/rtl/tcp_connection_demux_unit.sv
dv/tcp_connection_demux_unit_tb.sv
